// ===== src/sha_pkg.sv =====
// SHA-256 byte stream hasher: shared constants, types and round functions.
// Used by sha_round and the top level; no dependencies.
package sha_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned ChainWords = 8;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_COMP  = 5'b00100,
    ST_EMIT  = 5'b01000,
    ST_FEED  = 5'b10000
  } state_e;

  // Round constants.
  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    begin
      case (i)
        6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
        6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
        6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
        6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
        6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
        6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
        6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
        6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
        6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
        6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
        6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
        6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
        6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
        6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
        6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
        6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
        6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
        6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
        6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
        6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
        6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
        default: k = 32'hc67178f2;
      endcase
      return k;
    end
  endfunction

  // Initial hash values.
  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h;
    begin
      case (i)
        3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
        3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
        3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
        3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
      endcase
      return h;
    end
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== src/sha_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module sha_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== src/sha_round.sv =====
// SHA-256 compression round datapath: one round per cycle while step_i is high, on eight registers.
// Depends on sha_pkg.
module sha_round
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        load_i,
  input  logic [255:0] init_i,
  input  logic        step_i,
  input  logic [31:0] w_i,
  input  logic [5:0]  rnd_i,
  output logic [255:0] v_o
);
  logic [31:0] v_q [8];
  logic [31:0] t1, t2, big0, big1, ch, maj;

  always_comb begin
    big1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1   = v_q[7] + big1 + ch + round_k(rnd_i) + w_i;
    big0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2   = big0 + maj;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int i = 0; i < 8; i++) v_q[i] <= init_i[255-32*i -: 32];
    end else if (step_i) begin
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) v_o[255-32*i -: 32] = v_q[i];
  end
endmodule

// ===== src/sha256_byte_stream_hasher.sv =====
// Intake: a byte is taken while the block is idle; every 64th byte
// stalls the input while the window loads from RAM, the 64 rounds run, a writeback
// step passes and the feed-forward completes, limited by the single round unit.
// Finish: padding one byte per cycle (up to 64 per block), one or two
// compressions, then 8 digest words, one per cycle as the output accepts them.
// Reset is asynchronous, active low; chain words return to the initial values,
// fill and length clear.
module sha256_byte_stream_hasher
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  // Block buffer as 16 words in a RAM; byte writes merged in a word register.
  state_e      st_q, st_d;
  logic [5:0]  fill_q;
  logic [63:0] len_q;
  logic [31:0] h_q [8];
  logic [31:0] acc_q;          // word being assembled
  logic        fin_q;          // finishing message
  logic        last_blk_q;     // this compression is the final one
  logic [6:0]  rnd_q;          // round counter, 64 = writeback
  logic [31:0] w_q [16];       // message schedule window
  logic        wload_q;
  logic [4:0]  ld_q;           // words loaded from RAM
  logic [2:0]  oidx_q;

  logic        ram_we;
  logic [3:0]  ram_wa, ram_ra;
  logic [31:0] ram_wd, ram_rd;
  logic [255:0] v, hinit;
  logic [31:0] wnew, s0, s1, wcur, byte_word;
  logic        in_acc, out_acc;
  logic [7:0]  pad_byte;

  sha_ram #(.Width(WordW), .Depth(BlockWords)) u_buf (
    .clk_i, .we_i(ram_we), .waddr_i(ram_wa), .wdata_i(ram_wd),
    .raddr_i(ram_ra), .rdata_o(ram_rd));

  always_comb begin
    for (int i = 0; i < 8; i++) hinit[255-32*i -: 32] = h_q[i];
  end

  // schedule: first 16 rounds from the window, then expanded
  assign s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
  assign wnew = w_q[0] + s0 + w_q[9] + s1;
  assign wcur = w_q[0];

  sha_round u_round (
    .clk_i, .load_i(wload_q && ld_q == 5'd16), .init_i(hinit),
    .step_i(st_q == ST_COMP && !wload_q && rnd_q < 7'd64),
    .w_i(wcur), .rnd_i(rnd_q[5:0]), .v_o(v));

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign in_stall_o = (st_q != ST_IDLE);
  assign out_valid_o = (st_q == ST_EMIT);
  assign digest_word_o = h_q[oidx_q];
  assign word_index_o = oidx_q;
  assign last_word_o = (oidx_q == 3'd7);

  // padding byte at current fill position (the 0x80 is the finish byte): zero, length at 56..63 of the last block
  always_comb begin
    if (fill_q[5:3] == 3'd7 && last_blk_q)
      pad_byte = len_q[63 - 8*fill_q[2:0] -: 8];
    else
      pad_byte = 8'h00;
  end

  logic [7:0] wr_byte;
  logic       wr_en;
  always_comb begin
    wr_en = 1'b0;
    wr_byte = 8'h00;
    if (st_q == ST_IDLE && in_acc) begin
      wr_en = 1'b1;
      wr_byte = op_i ? 8'h80 : data_byte_i;
    end else if (st_q == ST_PAD) begin
      wr_en = 1'b1;
      wr_byte = pad_byte;
    end
    byte_word = acc_q;
    byte_word[31 - 8*fill_q[1:0] -: 8] = wr_byte;
    ram_we = wr_en && fill_q[1:0] == 2'd3;
    ram_wa = fill_q[5:2];
    ram_wd = byte_word;
    ram_ra = ld_q[3:0];
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (in_acc) begin
        if (fill_q == 6'd63 && !op_i) st_d = ST_COMP;
        else if (op_i) st_d = (fill_q == 6'd63) ? ST_COMP : ST_PAD;
      end
      ST_PAD:  if (fill_q == 6'd63) st_d = ST_COMP;
      ST_COMP: if (rnd_q == 7'd64) st_d = ST_FEED;
      ST_FEED: st_d = !fin_q ? ST_IDLE : (last_blk_q ? ST_EMIT : ST_PAD);
      ST_EMIT: if (out_acc && oidx_q == 3'd7) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      fill_q <= '0;
      len_q <= '0;
      fin_q <= 1'b0;
      last_blk_q <= 1'b0;
      rnd_q <= '0;
      wload_q <= 1'b0;
      ld_q <= '0;
      oidx_q <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
    end else begin
      st_q <= st_d;
      if (wr_en) begin
        acc_q <= byte_word;
        fill_q <= fill_q + 6'd1;
      end
      if (st_q == ST_IDLE && in_acc) begin
        if (!op_i) len_q <= len_q + 64'd1;
        else begin
          fin_q <= 1'b1;
          len_q <= {len_q[60:0], 3'b000};
          last_blk_q <= (fill_q < 6'd56);
        end
      end
      if (st_q == ST_PAD && fill_q == 6'd63) last_blk_q <= last_blk_q;
      // entering compression: load window from RAM
      if (st_d == ST_COMP && st_q != ST_COMP) begin
        wload_q <= 1'b1;
        ld_q <= '0;
        rnd_q <= '0;
      end else if (wload_q) begin
        if (ld_q != 5'd0) w_q[ld_q[3:0] - 4'd1] <= ram_rd;
        if (ld_q == 5'd16) wload_q <= 1'b0;
        ld_q <= ld_q + 5'd1;
      end else if (st_q == ST_COMP && rnd_q < 7'd64) begin
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
        w_q[15] <= wnew;
        rnd_q <= rnd_q + 7'd1;
      end
      if (st_q == ST_FEED) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v[255-32*i -: 32];
        if (fin_q && !last_blk_q) last_blk_q <= 1'b1;
        oidx_q <= '0;
      end
      if (st_q == ST_EMIT && out_acc) begin
        oidx_q <= oidx_q + 3'd1;
        if (oidx_q == 3'd7) begin
          for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
          len_q <= '0;
          fill_q <= '0;
          fin_q <= 1'b0;
          last_blk_q <= 1'b0;
        end
      end
    end
  end
endmodule

// ===== src/sha_checker.sv =====
// Port-level checks for the SHA-256 byte stream hasher, bound to the top level.
// Depends on sha256_byte_stream_hasher ports only.
module sha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] digest_word_o,
  input logic [2:0]  word_index_o,
  input logic        last_word_o
);
  // no intake while a digest is on the output
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken during digest output");
  // last flag marks word seven
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_word_o == (word_index_o == 3'd7))) else $error("last flag");
  // index advances by one per transaction within a digest
  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_word_o |=>
      out_valid_o && word_index_o == $past(word_index_o) + 3'd1) else $error("index");
  // stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(digest_word_o)) else $error("hold");
endmodule

bind sha256_byte_stream_hasher sha_checker u_sha_checker (.*);

// ===== verif/sha256_digest_checker.sv =====
// Digest checker for the SHA-256 byte stream hasher: watches both channels,
// computes expected digests with its own SHA-256 model and compares words.
// Uses no package; its port widths match those of the block.
`timescale 1ns / 100ps

module sha256_digest_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        op_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] digest_word_i,
  input  logic [2:0]  word_index_i,
  input  logic        last_word_i,
  output int          fail_count_o,
  output int          pending_words_o
);

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  // Round constants and initial chain values.
  localparam logic [31:0] KTAB [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
  localparam logic [31:0] HINIT [8] = '{
    32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
    32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

  logic [31:0]  chain [8];
  logic [7:0]   blk [64];
  int unsigned  fill;
  logic [63:0]  msg_len;
  digest_word_t digest_q [$];
  int           fails;

  assign fail_count_o    = fails;
  assign pending_words_o = digest_q.size();

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One SHA-256 block compression of blk into chain.
  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + w[i-7]
           + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
           + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endtask

  task automatic restart_message();
    for (int i = 0; i < 8; i++) chain[i] = HINIT[i];
    fill    = 0;
    msg_len = '0;
  endtask

  // Absorb a byte or pad, finish and queue the eight digest words.
  task automatic hash_transaction(logic op, logic [7:0] b);
    logic [63:0] bits;
    int unsigned n;
    if (op == OP_ABSORB) begin
      blk[fill] = b;
      fill++;
      msg_len++;
      if (fill == 64) begin
        compress_block();
        fill = 0;
      end
    end else begin
      bits   = msg_len << 3;
      n      = fill;
      blk[n] = 8'h80;
      n++;
      if (n > 56) begin
        while (n < 64) begin blk[n] = 8'h00; n++; end
        compress_block();
        n = 0;
      end
      while (n < 56) begin blk[n] = 8'h00; n++; end
      for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++) digest_q.push_back('{chain[i], 3'(i), i == 7});
      restart_message();
    end
  endtask

  // Sample both channels at each edge.
  always @(posedge clk_i or negedge rst_ni) begin
    digest_word_t exp_w;
    if (!rst_ni) begin
      restart_message();
      digest_q.delete();
      fails = 0;
    end else begin
      if (in_valid_i && !in_stall_i) hash_transaction(op_i, data_byte_i);
      if (out_valid_i && !out_stall_i) begin
        if (digest_q.size() == 0) begin
          $error("unexpected digest word %h", digest_word_i);
          fails++;
        end else begin
          exp_w = digest_q.pop_front();
          if (digest_word_i !== exp_w.word) begin
            $error("digest_word expected %h actual %h", exp_w.word, digest_word_i);
            fails++;
          end
          if (word_index_i !== exp_w.idx) begin
            $error("word_index expected %0d actual %0d", exp_w.idx, word_index_i);
            fails++;
          end
          if (last_word_i !== exp_w.last) begin
            $error("last_word expected %0d actual %0d", exp_w.last, last_word_i);
            fails++;
          end
        end
      end
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Top of the SHA-256 byte stream hasher testbench: clock, reset, message
// stimulus with bursts and stalls, and the verdict; uses sha256_digest_checker.
`timescale 1ns / 100ps

module tb_top;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;
  localparam int   IDLE_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        op_i = OP_ABSORB;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;
  int          fail_count;
  int          pending_words;
  int          idle_cycles = 0;
  int          hold_off = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sha256_byte_stream_hasher dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .op_i, .data_byte_i,
    .out_valid_o, .out_stall_i, .digest_word_o, .word_index_o, .last_word_o
  );

  sha256_digest_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .op_i, .data_byte_i,
    .out_valid_i(out_valid_o), .out_stall_i, .digest_word_i(digest_word_o),
    .word_index_i(word_index_o), .last_word_i(last_word_o),
    .fail_count_o(fail_count), .pending_words_o(pending_words)
  );

  // Sender: bursts of random length, random gaps in between.
  int burst_left = 0;

  task automatic offer(logic op, logic [7:0] b);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain_wait();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) offer(OP_ABSORB, 8'($urandom));
    offer(OP_FINISH, 8'($urandom));
  endtask

  // Receiver: random stall pattern, one long hold-off when asked.
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      out_stall_i <= 1'b1;
      hold_off    <= hold_off - 1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2: out_stall_i <= 1'b1;
        default: out_stall_i <= 1'b0;
      endcase
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message, finish with all-ones unused byte, byte extremes.
    offer(OP_FINISH, 8'hff);
    offer(OP_ABSORB, 8'h00);
    offer(OP_FINISH, 8'h00);
    offer(OP_ABSORB, 8'hff);
    offer(OP_ABSORB, 8'h55);
    offer(OP_ABSORB, 8'haa);
    offer(OP_FINISH, 8'h5a);
    drain_wait();
    // Long hold-off on the result side while the sender keeps offering.
    hold_off = 300;
    send_message(55);
    send_message(56);
    send_message(0);
    drain_wait();
    // Random messages, mostly short, a few across block boundaries.
    for (int n = 0; n < 4; n++) begin
      case ($urandom_range(0, 5))
        0:       send_message($urandom_range(55, 70));
        1:       send_message(64);
        2:       send_message($urandom_range(100, 130));
        default: send_message($urandom_range(0, 20));
      endcase
    end
    drain_wait();
    for (int n = 0; n < 5; n++) begin
      case ($urandom_range(0, 5))
        0:       send_message($urandom_range(55, 64));
        default: send_message($urandom_range(0, 12));
      endcase
    end
    drain_wait();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending_words == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
